/* src/ide_config_port_with_unlock_key_core_defines.svh */
// ----------------------------------------------------------------------------
// ide_config_port_with_unlock_key_core_defines.svh
// assertion macros shared by the checker of the config port core
// ----------------------------------------------------------------------------
`ifndef IDE_CONFIG_PORT_WITH_UNLOCK_KEY_CORE_DEFINES_SVH
`define IDE_CONFIG_PORT_WITH_UNLOCK_KEY_CORE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define ICP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("config port check failed");

// next-cycle implication, off while reset is held
`define ICP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("config port check failed");

// next-cycle implication that also covers reset itself
`define ICP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("config port reset check failed");

`endif

/* src/ide_cfg_pkg.sv */
// ----------------------------------------------------------------------------
// ide_cfg_pkg
// constants and types of the index/data config port with unlock key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ide_cfg_pkg;

  // access kinds
  localparam logic ACC_READ   = 1'b0;
  localparam logic ACC_WRITE  = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // unlock key and special indexes
  localparam logic [7:0] KEY_FIRST   = 8'h4A;
  localparam logic [7:0] KEY_SECOND  = 8'h6C;
  localparam logic [7:0] LOCK_INDEX  = 8'h34;
  localparam logic [7:0] CTRL_INDEX  = 8'hB0;
  localparam logic [7:0] TIMING_BASE = 8'hB1;
  localparam logic [7:0] LAST_INDEX  = 8'hB8;
  localparam logic [7:0] CTRL_RESET  = 8'hC0;
  localparam logic [7:0] NO_ANSWER   = 8'hFF;

  // channel enable bit positions in the control register
  localparam int unsigned PRI_BIT = 7;
  localparam int unsigned SEC_BIT = 6;

  localparam int unsigned TIMING_REGS = 8;
  localparam int unsigned TIMING_AW   = $clog2(TIMING_REGS);

  // key progress codes
  typedef enum logic [1:0] {
    KEY_IDLE  = 2'd0,
    KEY_HALF  = 2'd1,
    KEY_DONE  = 2'd2
  } key_state_t;

  // one captured bus access
  typedef struct packed {
    logic       req_type;
    logic       port_select;
    logic [7:0] write_data;
  } access_t;

  // one result beat
  typedef struct packed {
    logic       secondary_enable;
    logic       primary_enable;
    logic [7:0] read_data;
  } result_t;

endpackage

/* src/ide_config_port_with_unlock_key_core.sv */
// ----------------------------------------------------------------------------
// ide_config_port_with_unlock_key_core
// index/data configuration port of an IDE controller with a two-byte unlock
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: one beat per bus access; in_tuser[0] = write, in_tuser[1] =
//         data port, in_tdata[7:0] = write byte (ignored on reads).
//   out_* stream: exactly one beat per access; read byte (0 on writes, 0xFF
//         when nothing answers) plus the two channel enables as they stand
//         after the access.
//   An accepted input beat passes through the input register, then the decode
//   and state update into the result register. One access is taken every
//   cycle while out_tready is high; the state update of an access happens as it
//   moves from the input register into the result register.
//   If out_tready is low, the result register holds and the input register
//   fills; in_tready drops only when both are full. in_tready follows
//   out_tready in the same cycle.
//   Reset (rst_n low, synchronous) empties both registers, locks the port,
//   clears the index and key progress, sets the control register to 0xC0
//   (both channels on) and clears the timing registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ide_config_port_with_unlock_key_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] write_data
  input  logic [1:0]  in_tuser,   // [0] req_type, [1] port_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] primary_enable,
                                  // [9] secondary_enable, [15:10] zero
);

  // input register
  logic                   in_valid_r;
  ide_cfg_pkg::access_t   in_acc_r;

  // result register
  logic                   out_valid_r;
  ide_cfg_pkg::result_t   out_res_r;
  ide_cfg_pkg::result_t   out_res_nxt;

  // block state
  logic [7:0]             cur_index_r, cur_index_nxt;
  ide_cfg_pkg::key_state_t key_r, key_nxt;
  logic                   unlocked_r, unlocked_nxt;
  logic [7:0]             ctrl_r, ctrl_nxt;
  logic [7:0]             timing_r [ide_cfg_pkg::TIMING_REGS];

  logic                   out_free;
  logic                   advance;
  logic                   hit_ctrl;
  logic                   hit_timing;
  logic [7:0]             timing_off;
  logic [ide_cfg_pkg::TIMING_AW-1:0] timing_idx;
  logic                   timing_we;
  logic [7:0]             rd_byte;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_acc_r.req_type    <= in_tuser[0];
      in_acc_r.port_select <= in_tuser[1];
      in_acc_r.write_data  <= in_tdata;
    end
  end

  // register decode of the current index
  assign hit_ctrl   = (cur_index_r == ide_cfg_pkg::CTRL_INDEX);
  assign hit_timing = cur_index_r inside {[ide_cfg_pkg::TIMING_BASE:ide_cfg_pkg::LAST_INDEX]};
  assign timing_off = cur_index_r - ide_cfg_pkg::TIMING_BASE;
  assign timing_idx = timing_off[ide_cfg_pkg::TIMING_AW-1:0];

  // access decode and state update
  always_comb begin
    cur_index_nxt = cur_index_r;
    key_nxt       = key_r;
    unlocked_nxt  = unlocked_r;
    ctrl_nxt      = ctrl_r;
    timing_we     = 1'b0;
    rd_byte       = 8'd0;
    if (advance) begin
      case ({in_acc_r.req_type, in_acc_r.port_select})
        {ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX}: begin
          if (unlocked_r) begin
            if (cur_index_r == ide_cfg_pkg::LOCK_INDEX) begin
              unlocked_nxt = 1'b0;
              key_nxt      = ide_cfg_pkg::KEY_IDLE;
            end else begin
              cur_index_nxt = in_acc_r.write_data;
            end
          end else if (key_r == ide_cfg_pkg::KEY_IDLE &&
                       in_acc_r.write_data == ide_cfg_pkg::KEY_FIRST) begin
            key_nxt = ide_cfg_pkg::KEY_HALF;
          end else if (key_r == ide_cfg_pkg::KEY_HALF &&
                       in_acc_r.write_data == ide_cfg_pkg::KEY_SECOND) begin
            key_nxt      = ide_cfg_pkg::KEY_DONE;
            unlocked_nxt = 1'b1;
          end else begin
            key_nxt = ide_cfg_pkg::KEY_IDLE;
          end
        end
        {ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA}: begin
          if (hit_ctrl) begin
            ctrl_nxt = in_acc_r.write_data;
          end else if (hit_timing) begin
            timing_we = 1'b1;
          end
        end
        {ide_cfg_pkg::ACC_READ, ide_cfg_pkg::PORT_DATA}: begin
          if (hit_ctrl) begin
            rd_byte = ctrl_r;
          end else if (hit_timing) begin
            rd_byte = timing_r[timing_idx];
          end else begin
            rd_byte = ide_cfg_pkg::NO_ANSWER;
          end
        end
        {ide_cfg_pkg::ACC_READ, ide_cfg_pkg::PORT_INDEX}: begin
          if (unlocked_r) begin
            rd_byte = cur_index_r;
          end else begin
            key_nxt = ide_cfg_pkg::KEY_IDLE;
            rd_byte = ide_cfg_pkg::NO_ANSWER;
          end
        end
        default: begin
          rd_byte = ide_cfg_pkg::NO_ANSWER;
        end
      endcase
    end
    out_res_nxt.read_data        = rd_byte;
    out_res_nxt.primary_enable   = ctrl_nxt[ide_cfg_pkg::PRI_BIT];
    out_res_nxt.secondary_enable = ctrl_nxt[ide_cfg_pkg::SEC_BIT];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_index_r <= 8'd0;
      key_r       <= ide_cfg_pkg::KEY_IDLE;
      unlocked_r  <= 1'b0;
      ctrl_r      <= ide_cfg_pkg::CTRL_RESET;
    end else begin
      cur_index_r <= cur_index_nxt;
      key_r       <= key_nxt;
      unlocked_r  <= unlocked_nxt;
      ctrl_r      <= ctrl_nxt;
    end
  end

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ide_cfg_pkg::TIMING_REGS; i++) begin
        timing_r[i] <= 8'd0;
      end
    end else if (timing_we) begin
      timing_r[timing_idx] <= in_acc_r.write_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule

/* src/ide_cfg_checker.sv */
// ----------------------------------------------------------------------------
// ide_cfg_checker
// port-level checks of the config port core, bound into the core module
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ide_config_port_with_unlock_key_core_defines.svh"

module ide_cfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // no result beat straight after reset
  `ICP_ASSERT_RST(a_quiet_after_reset, !rst_n, !out_tvalid)

  // a stalled result beat holds its payload
  `ICP_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a ready sink never back-pressures the input side
  `ICP_ASSERT_IMPL(a_ready_passes_through, out_tready, in_tready)

  // an accepted beat moves through the input register into the result register when the sink is ready
  `ICP_ASSERT_NEXT(a_two_cycle_latency, (in_tvalid && in_tready) ##1 out_tready, out_tvalid)

endmodule

bind ide_config_port_with_unlock_key_core ide_cfg_checker u_ide_cfg_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the index/data config port with two-byte unlock key
// ----------------------------------------------------------------------------
// Bus accesses go in as stream beats. A model of the port, kept in step with
// every accepted beat, queues the expected read byte and channel enables. A
// checker pops one entry per result beat and compares it field by field.
// There are directed tests for the locked port, the key sequence and the
// register window. Two random runs use random idling on both sides, with one
// long output hold-off between them. A final test drives the lock index, after
// which every index write to the unlocked port locks it again.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CLK_PERIOD  = 12;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 420;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] write_data
  logic [1:0]  in_tuser;   // [0] req_type, [1] port_select
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] read_data, [8] primary_enable,
                           // [9] secondary_enable, [15:10] zero

  // model state of the port
  logic [7:0]              mdl_index;
  ide_cfg_pkg::key_state_t mdl_key;
  logic                    mdl_unlocked;
  logic [7:0]              mdl_ctrl;
  logic [7:0]              mdl_timing [ide_cfg_pkg::TIMING_REGS];

  ide_cfg_pkg::result_t pending_results [$];
  int         err_cnt;
  int         idle_cycles;
  bit         tx_idle;
  bit         rx_idle;
  int         rx_hold;

  ide_config_port_with_unlock_key_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // register window decode of the model
  function automatic bit in_timing_window(logic [7:0] idx);
    return (idx > ide_cfg_pkg::CTRL_INDEX) && (idx <= ide_cfg_pkg::LAST_INDEX);
  endfunction

  // apply one access to the model and return the beat it should produce
  function automatic ide_cfg_pkg::result_t predict_access(logic req, logic port,
                                                          logic [7:0] wd);
    ide_cfg_pkg::result_t res;
    logic [ide_cfg_pkg::TIMING_AW-1:0] sel;
    res = '0;
    sel = ide_cfg_pkg::TIMING_AW'(mdl_index - ide_cfg_pkg::TIMING_BASE);
    if (req == ide_cfg_pkg::ACC_WRITE && port == ide_cfg_pkg::PORT_DATA) begin
      if (mdl_index == ide_cfg_pkg::CTRL_INDEX) mdl_ctrl = wd;
      else if (in_timing_window(mdl_index)) mdl_timing[sel] = wd;
    end else if (req == ide_cfg_pkg::ACC_WRITE) begin
      if (mdl_unlocked) begin
        if (mdl_index == ide_cfg_pkg::LOCK_INDEX) begin
          mdl_unlocked = 1'b0;
          mdl_key      = ide_cfg_pkg::KEY_IDLE;
        end else begin
          mdl_index = wd;
        end
      end else if (mdl_key == ide_cfg_pkg::KEY_IDLE && wd == ide_cfg_pkg::KEY_FIRST) begin
        mdl_key = ide_cfg_pkg::KEY_HALF;
      end else if (mdl_key == ide_cfg_pkg::KEY_HALF && wd == ide_cfg_pkg::KEY_SECOND) begin
        mdl_key      = ide_cfg_pkg::KEY_DONE;
        mdl_unlocked = 1'b1;
      end else begin
        mdl_key = ide_cfg_pkg::KEY_IDLE;
      end
    end else if (port == ide_cfg_pkg::PORT_DATA) begin
      if (mdl_index == ide_cfg_pkg::CTRL_INDEX) res.read_data = mdl_ctrl;
      else if (in_timing_window(mdl_index)) res.read_data = mdl_timing[sel];
      else res.read_data = ide_cfg_pkg::NO_ANSWER;
    end else if (mdl_unlocked) begin
      res.read_data = mdl_index;
    end else begin
      mdl_key       = ide_cfg_pkg::KEY_IDLE;
      res.read_data = ide_cfg_pkg::NO_ANSWER;
    end
    res.primary_enable   = mdl_ctrl[ide_cfg_pkg::PRI_BIT];
    res.secondary_enable = mdl_ctrl[ide_cfg_pkg::SEC_BIT];
    return res;
  endfunction

  // offer one access, wait for it to be taken, then queue its result
  task automatic send_access(logic req, logic port, logic [7:0] wd);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {port, req};
    in_tdata  <= wd;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_access(req, port, wd));
  endtask

  // locked port straight after reset: nothing answers, writes do nothing
  task automatic test_locked_port();
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'hFF);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'hFF);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_SECOND);
  endtask

  // broken keys, then the key with a data access between its two bytes
  task automatic test_unlock_key();
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_SECOND);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'h5A);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_SECOND);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'h00);
  endtask

  // control register, window edges and outside the window
  task automatic test_register_window();
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::CTRL_INDEX);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'h80);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'h7F);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::LAST_INDEX);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'hFF);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, 8'hB9);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA,  8'h11);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, 8'hAF);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'hFF);
  endtask

  // one random access, shaped by the current lock state
  task automatic random_access();
    int        pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    b    = 8'($urandom);
    if (!mdl_unlocked) begin
      if (pick < 40) begin
        send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
      end else if (pick < 75) begin
        send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_SECOND);
      end else begin
        send_access(1'($urandom), 1'($urandom), b);
      end
    end else if (pick < 25) begin
      // the lock index is left to the last test, it cannot be left again
      if ($urandom_range(0, 3) != 0) b = ide_cfg_pkg::CTRL_INDEX + 8'($urandom_range(0, 8));
      else if ($urandom_range(0, 1) != 0) b = $urandom_range(0, 1) ? 8'hAF : 8'hB9;
      if (b == ide_cfg_pkg::LOCK_INDEX) b = 8'h33;
      send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, b);
    end else if (pick < 60) begin
      send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_DATA, b);
    end else if (pick < 90) begin
      send_access(ide_cfg_pkg::ACC_READ, ide_cfg_pkg::PORT_DATA, b);
    end else begin
      send_access(ide_cfg_pkg::ACC_READ, ide_cfg_pkg::PORT_INDEX, b);
    end
  endtask

  // long random run in segments with and without idling
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      random_access();
    end
  endtask

  // output held off while accesses keep coming, input must stall
  task automatic test_output_hold_off();
    tx_idle = 1'b0;
    rx_hold = 80;
    for (int i = 0; i < 12; i++) random_access();
  endtask

  // lock index: the next index write locks, and every later unlock relocks
  task automatic test_lock_index();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // open the port first, clearing any half-entered key
    if (!mdl_unlocked) begin
      send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, 8'h00);
      send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
      send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_SECOND);
    end
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::LOCK_INDEX);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::CTRL_INDEX);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'h00);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_DATA,  8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_FIRST);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::KEY_SECOND);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'h00);
    send_access(ide_cfg_pkg::ACC_WRITE, ide_cfg_pkg::PORT_INDEX, ide_cfg_pkg::CTRL_INDEX);
    send_access(ide_cfg_pkg::ACC_READ,  ide_cfg_pkg::PORT_INDEX, 8'h00);
  endtask

  // receiver: random stall before each beat, or one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = rx_idle ? $urandom_range(0, 18) : 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // result checker
  always @(posedge clk) begin
    ide_cfg_pkg::result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[7:0] !== exp_res.read_data ||
            out_tdata[8] !== exp_res.primary_enable ||
            out_tdata[9] !== exp_res.secondary_enable ||
            out_tdata[15:10] !== 6'd0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: rd exp %h got %h, pri exp %b got %b, sec exp %b got %b, pad %h",
                     exp_res.read_data, out_tdata[7:0], exp_res.primary_enable,
                     out_tdata[8], exp_res.secondary_enable, out_tdata[9],
                     out_tdata[15:10]);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = '0;
    in_tdata     = '0;
    err_cnt      = 0;
    idle_cycles  = 0;
    rx_hold      = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    mdl_index    = '0;
    mdl_key      = ide_cfg_pkg::KEY_IDLE;
    mdl_unlocked = 1'b0;
    mdl_ctrl     = ide_cfg_pkg::CTRL_RESET;
    for (int i = 0; i < ide_cfg_pkg::TIMING_REGS; i++) mdl_timing[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_locked_port();
    test_unlock_key();
    test_register_window();
    test_random_traffic();
    test_output_hold_off();
    test_random_traffic();
    test_lock_index();

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (6) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
